@@ src/mfbfr_pkg.sv @@
// Package for the MSB-first bit-field reader: request codes, the classified
// request record passed from the front end to the execution engine, and tables.
// Depends on nothing; every other file of the block but mfbfr_ram imports it.
`default_nettype none
package mfbfr_pkg;

	localparam int LEN_W   = 6;
	localparam int VALUE_W = 33;
	localparam int COUNT_W = 17;

	typedef enum logic [1:0] {
		FN_LOAD   = 2'd0,
		FN_READ   = 2'd1,
		FN_REWIND = 2'd2,
		FN_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		OP_LOAD,
		OP_READ,
		OP_SKIP,
		OP_REWIND,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [7:0]       data;
		logic             last;
		logic [LEN_W-1:0] len;
		logic             sgn;
	} req_t;

	localparam logic [7:0] LOW_MASK [0:8] = '{
		8'h00, 8'h01, 8'h03, 8'h07, 8'h0f, 8'h1f, 8'h3f, 8'h7f, 8'hff
	};

endpackage
`default_nettype wire

@@ src/msb_first_bit_field_reader.sv @@
// MSB-first bit-field reader over a byte frame buffer.
// Requests enter a queue on one side and results leave a queue on the other:
// an input request is taken when push is high and full is low; the oldest
// result sits on value, overrun and bits_consumed while empty is low, and
// leaves when pop is high. Every request gives exactly one result.
// A request is registered in the front queue; the engine takes it from there
// only in its idle state, so it works on one request at a time. A load,
// rewind, clear or zero-length read goes straight to the emit state, which
// writes the result register. Since the frame buffer is a synchronous RAM
// read one byte per access, a read goes through a run state and a data state
// for each frame byte it fetches; it takes the bits of a leading partial byte
// in the run state, and flags an overrun there if the frame runs out.
// The front queue holds two requests, so push may continue while the engine
// works or while a result waits. If pop stays low, the engine holds its
// finished result and then full rises.
// Reset empties both queues, empties the frame, rewinds the read position and
// makes the next load open a new frame. The RAM contents are not cleared.
// Depends on mfbfr_pkg, mfbfr_front, mfbfr_back and mfbfr_ram.
`default_nettype none
module msb_first_bit_field_reader #(
	parameter int BUFFER_BYTES   = 8192,
	parameter int MAX_FIELD_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [1:0]                        func,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              last_byte,
	input  wire logic [mfbfr_pkg::LEN_W-1:0]       length,
	input  wire logic                              signed_read,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic signed [mfbfr_pkg::VALUE_W-1:0]   value,
	output logic                                   overrun,
	output logic        [mfbfr_pkg::COUNT_W-1:0]   bits_consumed
);
	import mfbfr_pkg::*;

	logic req_valid;
	logic req_take;
	req_t req;

	mfbfr_front #(
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.length     (length),
		.signed_read(signed_read),
		.req_valid  (req_valid),
		.req        (req),
		.req_take   (req_take)
	);

	mfbfr_back #(
		.BUFFER_BYTES  (BUFFER_BYTES),
		.MAX_FIELD_BITS(MAX_FIELD_BITS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req          (req),
		.req_take     (req_take),
		.empty        (empty),
		.pop          (pop),
		.value        (value),
		.overrun      (overrun),
		.bits_consumed(bits_consumed)
	);

endmodule
`default_nettype wire

@@ src/mfbfr_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Depends on nothing.
`default_nettype none
module mfbfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

@@ src/mfbfr_front.sv @@
// Front end of the bit-field reader: a two-entry request queue that classifies
// each accepted request and saturates its field length.
// Depends on mfbfr_pkg.
`default_nettype none
module mfbfr_front #(
	parameter int MAX_FIELD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         push,
	output logic                              full,
	input  wire logic [1:0]                   func,
	input  wire logic [7:0]                   data_byte,
	input  wire logic                         last_byte,
	input  wire logic [mfbfr_pkg::LEN_W-1:0]  length,
	input  wire logic                         signed_read,
	output logic                              req_valid,
	output mfbfr_pkg::req_t                   req,
	input  wire logic                         req_take
);
	import mfbfr_pkg::*;

	localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_FIELD_BITS);

	req_t       entry_q [0:1];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	req_t       req_in;
	logic [LEN_W-1:0] len_sat;
	logic       do_push;
	logic       do_pop;

	always_comb begin
		len_sat = (length > MAX_LEN) ? MAX_LEN : length;
		req_in.data = data_byte;
		req_in.last = last_byte;
		req_in.len  = len_sat;
		req_in.sgn  = signed_read;
		case (func_t'(func))
			FN_LOAD:   req_in.op = OP_LOAD;
			FN_READ:   req_in.op = (len_sat == '0) ? OP_SKIP : OP_READ;
			FN_REWIND: req_in.op = OP_REWIND;
			FN_CLEAR:  req_in.op = OP_CLEAR;
			default:   req_in.op = OP_CLEAR;
		endcase
	end

	assign full      = (count_q == 2'd2);
	assign req_valid = (count_q != 2'd0);
	assign req       = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = req_take && req_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= req_in;
		end
	end

endmodule
`default_nettype wire

@@ src/mfbfr_back.sv @@
// Execution engine of the bit-field reader: frame buffer, read position,
// bit gathering and sign handling, and the result register.
// Depends on mfbfr_pkg and mfbfr_ram.
`default_nettype none
module mfbfr_back #(
	parameter int BUFFER_BYTES   = 8192,
	parameter int MAX_FIELD_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	input  wire mfbfr_pkg::req_t               req,
	output logic                               req_take,
	output logic                               empty,
	input  wire logic                          pop,
	output logic signed [mfbfr_pkg::VALUE_W-1:0] value,
	output logic                               overrun,
	output logic        [mfbfr_pkg::COUNT_W-1:0] bits_consumed
);
	import mfbfr_pkg::*;

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int TW = $clog2(BUFFER_BYTES + 1);
	localparam int CW = $clog2(BUFFER_BYTES + 2);
	localparam int FW = MAX_FIELD_BITS;
	localparam int IW = $clog2(MAX_FIELD_BITS);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DATA,
		ST_EMIT
	} state_t;

	state_t           state_q;
	logic [TW-1:0]    total_q;
	logic [CW-1:0]    counter_q;
	logic [3:0]       bits_left_q;
	logic [7:0]       cur_q;
	logic             closed_q;
	logic [FW-1:0]    acc_q;
	logic [LEN_W-1:0] rem_q;
	logic [LEN_W-1:0] len_q;
	logic             sgn_q;
	logic             over_q;
	logic             out_valid_q;

	logic [TW-1:0]    load_base;
	logic             load_room;
	logic             ram_we;
	logic             ram_re;
	logic [7:0]       ram_rdata;
	logic [7:0]       src_byte;
	logic [3:0]       src_bl;
	logic [3:0]       take;
	logic [7:0]       chunk;
	logic [LEN_W-1:0] new_rem;
	logic [FW-1:0]    acc_next;
	logic [LEN_W-1:0] len_m1;
	logic             sign_bit;
	logic [VALUE_W-1:0] value_ext;
	logic [VALUE_W-1:0] value_fin;
	logic [COUNT_W-1:0] consumed;
	logic             slot_free;
	logic             can_fetch;

	assign load_base = closed_q ? '0 : total_q;
	assign load_room = (load_base < TW'(BUFFER_BYTES));
	assign req_take  = req_valid && (state_q == ST_IDLE);
	assign ram_we    = req_take && (req.op == OP_LOAD) && load_room;
	assign can_fetch = (counter_q < CW'(total_q));
	assign ram_re    = (state_q == ST_RUN) && (bits_left_q == 4'd0) && can_fetch;

	mfbfr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_frame_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(load_base[AW-1:0]),
		.wdata(req.data),
		.re   (ram_re),
		.raddr(counter_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	always_comb begin
		src_byte = (state_q == ST_DATA) ? ram_rdata : cur_q;
		src_bl   = (state_q == ST_DATA) ? 4'd8 : bits_left_q;
		take     = ({2'b00, src_bl} < rem_q) ? src_bl : rem_q[3:0];
		chunk    = (src_byte >> (src_bl - take)) & LOW_MASK[take];
		new_rem  = rem_q - LEN_W'(take);
		acc_next = acc_q | (FW'(chunk) << new_rem);
	end

	always_comb begin
		len_m1    = len_q - LEN_W'(1);
		sign_bit  = sgn_q && (len_q != '0) && acc_q[len_m1[IW-1:0]];
		value_ext = VALUE_W'(acc_q);
		value_fin = sign_bit ? (value_ext - (VALUE_W'(1) << len_q)) : value_ext;
		consumed  = (COUNT_W'(counter_q) << 3) - COUNT_W'(bits_left_q);
		slot_free = !out_valid_q || pop;
	end

	assign empty = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			total_q       <= '0;
			counter_q     <= '0;
			bits_left_q   <= 4'd0;
			cur_q         <= 8'd0;
			closed_q      <= 1'b1;
			acc_q         <= '0;
			rem_q         <= '0;
			len_q         <= '0;
			sgn_q         <= 1'b0;
			over_q        <= 1'b0;
			out_valid_q   <= 1'b0;
			value         <= '0;
			overrun       <= 1'b0;
			bits_consumed <= '0;
		end else begin
			if (pop && out_valid_q && (state_q != ST_EMIT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						acc_q  <= '0;
						over_q <= 1'b0;
						len_q  <= req.len;
						rem_q  <= req.len;
						sgn_q  <= req.sgn && (req.op == OP_READ);
						state_q <= ST_EMIT;
						case (req.op)
							OP_LOAD: begin
								total_q     <= load_room ? (load_base + TW'(1)) : load_base;
								closed_q    <= req.last;
								counter_q   <= '0;
								bits_left_q <= 4'd0;
								cur_q       <= 8'd0;
							end
							OP_READ: begin
								state_q <= ST_RUN;
							end
							OP_REWIND: begin
								counter_q   <= '0;
								bits_left_q <= 4'd0;
								cur_q       <= 8'd0;
							end
							OP_CLEAR: begin
								total_q     <= '0;
								closed_q    <= 1'b1;
								counter_q   <= '0;
								bits_left_q <= 4'd0;
								cur_q       <= 8'd0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_RUN: begin
					if (bits_left_q == 4'd0) begin
						if (can_fetch) begin
							counter_q <= counter_q + CW'(1);
							state_q   <= ST_DATA;
						end else begin
							if (counter_q == CW'(total_q)) begin
								counter_q <= counter_q + CW'(1);
							end
							cur_q   <= 8'd0;
							over_q  <= 1'b1;
							state_q <= ST_EMIT;
						end
					end else begin
						acc_q       <= acc_next;
						rem_q       <= new_rem;
						bits_left_q <= src_bl - take;
						if (new_rem == '0) begin
							state_q <= ST_EMIT;
						end
					end
				end
				ST_DATA: begin
					cur_q       <= ram_rdata;
					acc_q       <= acc_next;
					rem_q       <= new_rem;
					bits_left_q <= src_bl - take;
					state_q     <= (new_rem == '0) ? ST_EMIT : ST_RUN;
				end
				ST_EMIT: begin
					if (slot_free) begin
						out_valid_q   <= 1'b1;
						value         <= value_fin;
						overrun       <= over_q;
						bits_consumed <= consumed;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire
